// ===== rtl/lpc_pkg.sv =====
// Package for the lane point clustering block: result kinds, state encoding,
// configuration register indices and fixed widths. No dependencies.
package lpc_pkg;

  localparam int unsigned FeatW   = 16;
  localparam int unsigned PointW  = 17;
  localparam int unsigned CountW  = 17;
  localparam int unsigned DistW   = 34;
  localparam int unsigned CountMax = 65536;

  typedef enum logic [1:0] {
    KIND_JOIN   = 2'd0,
    KIND_NEW    = 2'd1,
    KIND_DROP   = 2'd2,
    KIND_REPORT = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIST,
    ST_CMP,
    ST_DIV,
    ST_DIVNEXT,
    ST_PEMIT,
    ST_RPT,
    ST_REMIT
  } state_t;

  typedef enum logic [1:0] {
    REG_THRESH = 2'd0,
    REG_DIST   = 2'd1,
    REG_WIDTH  = 2'd2,
    REG_HEIGHT = 2'd3
  } cfg_reg_t;

endpackage

// ===== rtl/lpc_divider.sv =====
// Restoring divider for the running-mean update, one quotient bit per cycle.
// Depends on lpc_pkg.
module lpc_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [33:0] dividend,   // magnitude, below 2^34
  input  logic [17:0] divisor,    // nonzero
  output logic        done,
  output logic [33:0] quotient
);
  import lpc_pkg::*;

  logic [33:0] quo_r, quo_nxt;
  logic [34:0] rem_r, rem_nxt;
  logic [17:0] dvs_r, dvs_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [34:0] trial;

  // One shift and subtract step per cycle.
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r[33:0], quo_r[33]};
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = 6'd34;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {17'd0, dvs_r}) begin
        rem_nxt = trial - {17'd0, dvs_r};
        quo_nxt = {quo_r[32:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[32:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = busy_r && (cnt_r == 6'd1);
  assign quotient = {quo_r[32:0], (trial >= {17'd0, dvs_r})};
endmodule

// ===== rtl/lane_point_clustering.sv =====
// Top level of the lane point clustering block: sequencer, lane tables and
// one shared multiplier. Depends on lpc_pkg and lpc_divider.
// An item is taken in ST_IDLE. Each lane scanned squares the difference of every
// feature component on the shared multiplier and accumulates it, then compares. A join
// then per component forms a product, starts the divider and awaits a 34-step division.
// Point results and lane reports are each held until out_tready accepts them.
// The input is not ready again until every result of an item is taken.
// Reset (synchronous, rst_n low) empties the lane table and loads default registers.
module lane_point_clustering #(
  parameter int MAX_LANES = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // confidence, offset_row, offset_col, feature_a..d, cell_row, cell_col
  input  logic [127:0] in_tdata,
  input  logic         in_tlast,  // last_cell
  output logic         out_tvalid,
  input  logic         out_tready,
  // lane number, point_x, point_y, lane_points, lane_kept
  output logic [55:0]  out_tdata,
  output logic [1:0]   out_tuser, // result_kind
  output logic         out_tlast, // last_result
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import lpc_pkg::*;

  localparam int LW = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
  localparam int NW = $clog2(MAX_LANES + 1);
  localparam int RptN = (MAX_LANES < 16) ? MAX_LANES : 16;

  // Configuration registers.
  logic signed [15:0] thr_r;
  logic [31:0] dthr_r;
  logic [8:0]  gw_r, gh_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= 16'sd3318;
      dthr_r <= 32'd3690988;
      gw_r   <= 9'd64;
      gh_r   <= 9'd32;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESH: thr_r  <= cfg_data[15:0];
        REG_DIST:   dthr_r <= cfg_data;
        REG_WIDTH:  gw_r   <= cfg_data[8:0];
        REG_HEIGHT: gh_r   <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Lane tables.
  logic signed [15:0] mean_r [MAX_LANES][4];
  logic [CountW-1:0]  cnt_r  [MAX_LANES];
  logic [NW-1:0]      used_r;

  // Item registers.
  state_t st_r, st_nxt;
  logic signed [15:0] f_r [4];
  logic [PointW-1:0]  px_r, py_r;
  logic               last_r;
  logic [LW-1:0]      idx_r;
  logic [1:0]         comp_r;
  logic [DistW-1:0]   acc_r;
  logic signed [33:0] prod_r;
  logic               prod_v_r;
  kind_t              kind_r;
  logic signed [15:0] newm_r [4];

  // Input decode.
  logic signed [15:0] i_conf, i_orow, i_ocol;
  logic signed [17:0] i_x, i_y;
  logic               i_keep;
  assign i_conf = in_tdata[15:0];
  assign i_orow = in_tdata[31:16];
  assign i_ocol = in_tdata[47:32];
  assign i_x = $signed({2'b00, in_tdata[127:120], 8'd0}) + 18'(i_ocol);
  assign i_y = $signed({2'b00, in_tdata[119:112], 8'd0}) + 18'(i_orow);
  assign i_keep = (i_conf > thr_r) && !i_x[17] && !i_y[17]
               && (i_x <= $signed({1'b0, gw_r, 8'd0}))
               && (i_y <= $signed({1'b0, gh_r, 8'd0}));

  // Shared multiplier: difference squared in distance scan, mean times count in
  // the update.
  logic signed [16:0] diff;
  logic signed [17:0] mop_b;
  logic signed [16:0] mop_a;
  logic signed [34:0] mprod;
  assign diff  = 17'(mean_r[idx_r][comp_r]) - 17'(f_r[comp_r]);
  always_comb begin
    if (st_r == ST_DIST) begin
      mop_a = diff;
      mop_b = 18'(diff);
    end else begin
      mop_a = 17'(mean_r[idx_r][comp_r]);
      mop_b = $signed({1'b0, cnt_r[idx_r]});
    end
  end
  assign mprod = mop_a * mop_b;

  // Running sum and divider.
  logic signed [34:0] sum;
  logic [33:0] mag;
  logic        div_start, div_done;
  logic [33:0] quo;
  logic [17:0] dvs;
  assign sum = 35'(prod_r) + 35'(f_r[comp_r]);
  assign mag = sum[34] ? 34'(-sum) : 34'(sum);
  assign dvs = {1'b0, cnt_r[idx_r]} + 18'd1;
  lpc_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend(34'({mag, 1'b0} + {17'd0, dvs})),
    .divisor(dvs), .done(div_done), .quotient(quo)
  );
  // Rounded quotient: (2m+d)/(2d) is the floor of (2m+d)/d halved.
  logic [15:0] qmag;
  assign qmag = quo[16:1];

  logic        last_lane, have_lanes, rpt_end;
  logic [NW:0] idx_inc;
  assign have_lanes = used_r != '0;
  assign idx_inc    = (NW+1)'(idx_r) + (NW+1)'(1);
  assign last_lane  = idx_inc >= (NW+1)'(used_r);
  assign rpt_end    = last_lane || (idx_inc >= (NW+1)'(RptN));

  // Next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (in_tvalid) begin
        if (i_keep) st_nxt = (used_r != '0) ? ST_DIST : ST_PEMIT;
        else if (in_tlast && have_lanes) st_nxt = ST_RPT;
      end
      ST_DIST: if (comp_r == 2'd3 && prod_v_r) st_nxt = ST_CMP;
      ST_CMP: begin
        if (acc_r <= {2'b0, dthr_r}) st_nxt = ST_DIV;
        else if (last_lane) st_nxt = ST_PEMIT;
        else st_nxt = ST_DIST;
      end
      ST_DIV: if (prod_v_r) st_nxt = ST_DIVNEXT;
      ST_DIVNEXT: if (div_done) st_nxt = (comp_r == 2'd3) ? ST_PEMIT : ST_DIV;
      ST_PEMIT: if (out_tready)
        st_nxt = (last_r && have_lanes) ? ST_RPT : ST_IDLE;
      ST_RPT: st_nxt = ST_REMIT;
      ST_REMIT: if (out_tready)
        st_nxt = rpt_end ? ST_IDLE : ST_RPT;
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign div_start = (st_r == ST_DIV) && prod_v_r;
  assign in_tready = (st_r == ST_IDLE);

  // Operand phase flag: alternates while the multiplier serves a step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
    end else if (st_r == ST_DIST || st_r == ST_DIV) begin
      prod_v_r <= !prod_v_r;
    end else begin
      prod_v_r <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      used_r   <= '0;
      for (int i = 0; i < MAX_LANES; i++) cnt_r[i] <= '0;
    end else begin
      st_r     <= st_nxt;
      case (st_r)
        ST_IDLE: if (in_tvalid) begin
          for (int c = 0; c < 4; c++) f_r[c] <= in_tdata[48+16*c +: 16];
          px_r   <= i_x[16:0];
          py_r   <= i_y[16:0];
          last_r <= in_tlast;
          idx_r  <= '0;
          comp_r <= '0;
          acc_r  <= '0;
          if (i_keep && used_r == '0) begin
            kind_r <= KIND_NEW;
            for (int c = 0; c < 4; c++) mean_r[0][c] <= in_tdata[48+16*c +: 16];
            cnt_r[0] <= 17'd1;
            used_r   <= NW'(1);
          end else if (!i_keep && in_tlast && have_lanes) begin
            kind_r <= KIND_REPORT;
          end else if (!i_keep && in_tlast) begin
            for (int i = 0; i < MAX_LANES; i++) cnt_r[i] <= '0;
          end
        end
        ST_DIST: begin
          if (prod_v_r) begin
            acc_r  <= acc_r + DistW'(mprod[33:0]);
            comp_r <= comp_r + 2'd1;
          end
        end
        ST_CMP: begin
          acc_r  <= '0;
          comp_r <= '0;
          if (acc_r <= {2'b0, dthr_r}) begin
            kind_r <= KIND_JOIN;
          end else if (last_lane) begin
            if ((NW+1)'(used_r) < (NW+1)'(MAX_LANES)) begin
              kind_r <= KIND_NEW;
              idx_r  <= LW'(used_r);
              for (int c = 0; c < 4; c++) mean_r[LW'(used_r)][c] <= f_r[c];
              cnt_r[LW'(used_r)] <= 17'd1;
              used_r <= used_r + NW'(1);
            end else begin
              kind_r <= KIND_DROP;
              idx_r  <= '0;
            end
          end else begin
            idx_r <= idx_r + LW'(1);
          end
        end
        ST_DIV: begin
          if (!prod_v_r) prod_r <= mprod[33:0];
        end
        ST_DIVNEXT: if (div_done) begin
          newm_r[comp_r] <= sum[34] ? -$signed(qmag) : $signed(qmag);
          comp_r <= comp_r + 2'd1;
          if (comp_r == 2'd3) begin
            for (int c = 0; c < 3; c++) mean_r[idx_r][c] <= newm_r[c];
            mean_r[idx_r][3] <= sum[34] ? -$signed(qmag) : $signed(qmag);
            if (cnt_r[idx_r] < CountW'(CountMax)) cnt_r[idx_r] <= cnt_r[idx_r] + CountW'(1);
          end
        end
        ST_PEMIT: if (out_tready) begin
          idx_r <= (last_r && have_lanes) ? '0 : idx_r;
          if (last_r && have_lanes) kind_r <= KIND_REPORT;
          if (last_r && !have_lanes) for (int i = 0; i < MAX_LANES; i++) cnt_r[i] <= '0;
        end
        ST_REMIT: if (out_tready) begin
          if (st_nxt == ST_IDLE) begin
            used_r <= '0;
            for (int i = 0; i < MAX_LANES; i++) cnt_r[i] <= '0;
          end else begin
            idx_r <= idx_r + LW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Outputs.
  logic rpt;
  assign rpt = (st_r == ST_REMIT);
  assign out_tvalid = (st_r == ST_PEMIT) || rpt;
  assign out_tuser  = kind_r;
  assign out_tlast  = rpt ? rpt_end : !(last_r && have_lanes);
  always_comb begin
    out_tdata = '0;
    out_tdata[3:0] = 4'(idx_r);
    if (rpt) begin
      out_tdata[54:38] = cnt_r[idx_r];
      out_tdata[55]    = cnt_r[idx_r] >= 17'd2;
    end else begin
      out_tdata[20:4]  = px_r;
      out_tdata[37:21] = py_r;
    end
  end
endmodule

// ===== rtl/lpc_checker.sv =====
// Port-level checks for lane_point_clustering, bound to the top level.
// Depends on lpc_pkg.
module lpc_checker (
  input logic clk, rst_n, in_tvalid, in_tready, out_tvalid, out_tready,
  input logic [1:0] out_tuser,
  input logic [55:0] out_tdata
);
  import lpc_pkg::*;
  a_noacc: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped");
  a_rpt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_REPORT |-> out_tdata[37:4] == '0)
    else $error("report carries a point");
  a_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_DROP |-> out_tdata[3:0] == '0)
    else $error("drop has lane index");
endmodule

bind lane_point_clustering lpc_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tuser(out_tuser),
  .out_tdata(out_tdata)
);
